### rtl/core/nmqe_pkg.sv
// ----------------------------------------------------------------------------
// nmqe_pkg
// Shared types, widths, defaults and helper functions of the named mailbox
// queue engine.
// ----------------------------------------------------------------------------
package nmqe_pkg;

    // default configuration
    localparam int unsigned QUEUES_DEF     = 16;
    localparam int unsigned MSGS_DEF       = 16;
    localparam int unsigned MSG_BYTES_DEF  = 8;
    localparam int unsigned NAME_BYTES_DEF = 8;

    // fixed field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned SENDER_W = 16;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned MLEN_W   = 4;
    localparam int unsigned USED_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 2'd0,
        KIND_POST    = 2'd1,
        KIND_RECEIVE = 2'd2,
        KIND_DESTROY = 2'd3
    } t_kind;

    // keeps the low nbytes bytes of a word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [MLEN_W-1:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (MLEN_W'(i) < nbytes) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // name ends at its first zero byte or after limit bytes
    function automatic logic [KEY_W-1:0] normalize_name(input logic [KEY_W-1:0] key,
                                                        input logic [MLEN_W-1:0] limit);
        logic [KEY_W-1:0] nm;
        logic             alive;
        nm    = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (key[8*i +: 8] == 8'h00 || MLEN_W'(i) >= limit) begin
                alive = 1'b0;
            end
            if (alive) begin
                nm[8*i +: 8] = key[8*i +: 8];
            end
        end
        return nm;
    endfunction

endpackage

### rtl/core/nmqe_if.sv
// ----------------------------------------------------------------------------
// nmqe request and response channels
// Valid/ready channels carrying one operation and one result per transaction.
// ----------------------------------------------------------------------------
interface nmqe_req_if import nmqe_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    name_key;
    logic [SENDER_W-1:0] sender_id;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   payload;

    modport source (output valid, kind, name_key, sender_id, length, payload, input ready);
    modport sink   (input valid, kind, name_key, sender_id, length, payload, output ready);
endinterface

interface nmqe_rsp_if import nmqe_pkg::*;;
    logic                valid;
    logic                ready;
    logic                status;
    logic [MLEN_W-1:0]   msg_length;
    logic [SENDER_W-1:0] msg_sender;
    logic [DATA_W-1:0]   msg_data;
    logic [USED_W-1:0]   slots_in_use;

    modport source (output valid, status, msg_length, msg_sender, msg_data, slots_in_use,
                    input ready);
    modport sink   (input valid, status, msg_length, msg_sender, msg_data, slots_in_use,
                    output ready);
endinterface

### rtl/core/nmqe_ram.sv
// ----------------------------------------------------------------------------
// nmqe_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nmqe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/named_mailbox_queue_engine_top.sv
// ----------------------------------------------------------------------------
// named_mailbox_queue_engine_top
// Named message rings: slot names and valid flags in flops for a parallel
// name match, ring pointers and messages in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | modport | contents
//  i_req   | in  | sink    | kind, name_key, sender_id, length, payload
//  o_rsp   | out | source  | status, msg_length, msg_sender, msg_data, slots_in_use
//
//  one transaction at a time: accept, slot match with pointer ram read,
//  pointer/message ram access, result load; set by the pointer ram
//  read-modify-write and the message ram read latency; the next accept
//  waits for that result load, but a result waiting in the output register
//  does not block the next accept; it only holds the following result load
//  reset clears slot flags and the use count; rams need no clearing pass
// ----------------------------------------------------------------------------
module named_mailbox_queue_engine_top import nmqe_pkg::*; #(
    parameter int unsigned QUEUES     = QUEUES_DEF,
    parameter int unsigned MSGS       = MSGS_DEF,
    parameter int unsigned MSG_BYTES  = MSG_BYTES_DEF,
    parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nmqe_req_if.sink    i_req,
    nmqe_rsp_if.source  o_rsp
);
    localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int unsigned MW = $clog2(MSGS);
    localparam int unsigned FW = $clog2(MSGS + 1);
    localparam int unsigned CW = $clog2(QUEUES + 1);
    localparam int unsigned AW = $clog2(QUEUES * MSGS);
    localparam int unsigned PW = 2 * MW + FW;
    localparam int unsigned SW = DATA_W + MLEN_W + SENDER_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [KEY_W-1:0]    r_name;
    logic [SENDER_W-1:0] r_sender;
    logic [MLEN_W-1:0]   r_len;
    logic [DATA_W-1:0]   r_payload;
    logic                r_slot_valid [QUEUES];
    logic [KEY_W-1:0]    r_slot_name  [QUEUES];
    logic [CW-1:0]       r_used, n_used;
    logic [QW-1:0]       r_sel;
    logic                r_found, r_claim, r_status, r_rd;
    logic                r_out_valid;
    logic                r_out_status;
    logic [MLEN_W-1:0]   r_out_len;
    logic [SENDER_W-1:0] r_out_sender;
    logic [DATA_W-1:0]   r_out_data;
    logic [USED_W-1:0]   r_out_used;

    logic                req_acc;
    logic [MLEN_W-1:0]   len_clamped;
    logic                hit, free_any;
    logic [QW-1:0]       hit_idx, free_idx, sel;
    logic                found;
    logic [PW-1:0]       ptr_rdata, ptr_cur, ptr_wdata;
    logic                ptr_we;
    logic [MW-1:0]       head, tail, head_nx, tail_nx;
    logic [FW-1:0]       fill;
    logic                msg_we, msg_re;
    logic [AW-1:0]       msg_addr;
    logic [SW-1:0]       msg_rdata;
    logic                upd_status, do_release;
    logic                out_free;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign len_clamped = (i_req.length > LEN_W'(MSG_BYTES)) ? MLEN_W'(MSG_BYTES)
                                                             : MLEN_W'(i_req.length);

    // parallel name match; descending scan leaves the lowest index
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int q = QUEUES - 1; q >= 0; q--) begin
            if (r_slot_valid[q] && r_slot_name[q] == r_name) begin
                hit     = 1'b1;
                hit_idx = QW'(q);
            end
            if (!r_slot_valid[q]) begin
                free_any = 1'b1;
                free_idx = QW'(q);
            end
        end
        sel   = hit ? hit_idx : free_idx;
        found = hit || ((r_kind == KIND_CREATE || r_kind == KIND_POST) && free_any);
    end

    // a freshly claimed slot starts with cleared pointers
    assign ptr_cur = r_claim ? '0 : ptr_rdata;
    assign head    = ptr_cur[PW-1 -: MW];
    assign tail    = ptr_cur[FW +: MW];
    assign fill    = ptr_cur[FW-1:0];
    assign head_nx = (head == MW'(MSGS - 1)) ? '0 : head + 1'b1;
    assign tail_nx = (tail == MW'(MSGS - 1)) ? '0 : tail + 1'b1;

    always_comb begin
        upd_status = 1'b0;
        do_release = 1'b0;
        ptr_we     = 1'b0;
        ptr_wdata  = '0;
        msg_we     = 1'b0;
        msg_re     = 1'b0;
        if (r_state == ST_UPDATE) begin
            unique case (r_kind)
                KIND_CREATE: begin
                    upd_status = !r_found;
                    ptr_we     = r_claim;
                end
                KIND_POST: begin
                    if (!r_found || fill == FW'(MSGS)) begin
                        upd_status = 1'b1;
                        ptr_we     = r_claim;
                    end else begin
                        msg_we    = 1'b1;
                        ptr_we    = 1'b1;
                        ptr_wdata = {head, tail_nx, fill + 1'b1};
                    end
                end
                KIND_RECEIVE: begin
                    if (!r_found || fill == '0) begin
                        upd_status = 1'b1;
                    end else begin
                        msg_re    = 1'b1;
                        ptr_we    = 1'b1;
                        ptr_wdata = {head_nx, tail, fill - 1'b1};
                    end
                end
                KIND_DESTROY: begin
                    do_release = r_found;
                end
                default: begin
                    upd_status = 1'b1;
                end
            endcase
        end
    end

    assign msg_addr = AW'(r_sel) * AW'(MSGS) + AW'((r_kind == KIND_POST) ? tail : head);

    always_comb begin
        n_used = r_used;
        if (r_state == ST_UPDATE) begin
            if (r_claim) begin
                n_used = r_used + 1'b1;
            end else if (do_release) begin
                n_used = r_used - 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (req_acc) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    nmqe_ram #(
        .WIDTH (PW),
        .DEPTH (QUEUES)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_sel),
        .i_wdata (ptr_wdata),
        .i_re    (r_state == ST_LOOKUP),
        .i_raddr (sel),
        .o_rdata (ptr_rdata)
    );

    nmqe_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUES * MSGS)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (msg_addr),
        .i_wdata ({r_payload, r_len, r_sender}),
        .i_re    (msg_re),
        .i_raddr (msg_addr),
        .o_rdata (msg_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            for (int q = 0; q < QUEUES; q++) begin
                r_slot_valid[q] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == ST_UPDATE && r_claim) begin
                r_slot_valid[r_sel] <= 1'b1;
            end else if (do_release) begin
                r_slot_valid[r_sel] <= 1'b0;
            end
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind    <= t_kind'(i_req.kind);
            r_name    <= normalize_name(i_req.name_key, MLEN_W'(NAME_BYTES));
            r_sender  <= i_req.sender_id;
            r_len     <= len_clamped;
            r_payload <= i_req.payload & byte_mask(len_clamped);
        end
        if (r_state == ST_LOOKUP) begin
            r_sel   <= sel;
            r_found <= found;
            r_claim <= found && !hit;
        end
        if (r_state == ST_UPDATE) begin
            r_status <= upd_status;
            r_rd     <= msg_re;
            if (r_claim) begin
                r_slot_name[r_sel] <= r_name;
            end
        end
        if (r_state == ST_FINISH && out_free) begin
            r_out_status <= r_status;
            r_out_len    <= r_rd ? msg_rdata[SENDER_W +: MLEN_W] : '0;
            r_out_sender <= r_rd ? msg_rdata[SENDER_W-1:0] : '0;
            r_out_data   <= r_rd ? msg_rdata[SW-1 -: DATA_W] : '0;
            r_out_used   <= USED_W'(r_used);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.msg_length   = r_out_len;
    assign o_rsp.msg_sender   = r_out_sender;
    assign o_rsp.msg_data     = r_out_data;
    assign o_rsp.slots_in_use = r_out_used;
endmodule

### rtl/core/nmqe_checker.sv
// ----------------------------------------------------------------------------
// nmqe_checker
// Port-level checks of the named mailbox queue engine, bound to the top level.
// ----------------------------------------------------------------------------
module nmqe_checker import nmqe_pkg::*; #(
    parameter int unsigned QUEUES    = QUEUES_DEF,
    parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic                i_status,
    input logic [MLEN_W-1:0]   i_msg_length,
    input logic [SENDER_W-1:0] i_msg_sender,
    input logic [DATA_W-1:0]   i_msg_data,
    input logic [USED_W-1:0]   i_slots_in_use
);
    logic       req_acc, rsp_acc;
    logic [2:0] r_pending, n_pending;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_pending = r_pending;
        if (req_acc && !rsp_acc) begin
            n_pending = r_pending + 1'b1;
        end else if (rsp_acc && !req_acc) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // every result belongs to an operation taken earlier
    a_no_orphan_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc |-> r_pending != '0)
        else $error("result without a pending operation");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_msg_data) && $stable(i_slots_in_use))
        else $error("stalled result changed");

    // failed operations carry no message
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status |-> i_msg_length == '0 && i_msg_sender == '0
            && i_msg_data == '0)
        else $error("failed operation returned message fields");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_msg_length <= MLEN_W'(MSG_BYTES))
        else $error("message length above limit");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_slots_in_use) <= QUEUES)
        else $error("slot count above number of slots");
endmodule

bind named_mailbox_queue_engine_top nmqe_checker #(
    .QUEUES    (QUEUES),
    .MSG_BYTES (MSG_BYTES)
) u_nmqe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_msg_length   (o_rsp.msg_length),
    .i_msg_sender   (o_rsp.msg_sender),
    .i_msg_data     (o_rsp.msg_data),
    .i_slots_in_use (o_rsp.slots_in_use)
);

### verif/nmqe_mailbox_checker.sv
// ----------------------------------------------------------------------------
// nmqe_mailbox_checker
// Watches the request and response channels of the mailbox engine, keeps its
// own copy of the slot table and message rings, and compares each result
// transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module nmqe_mailbox_checker import nmqe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nmqe_req_if  i_req,
    nmqe_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending
);

    localparam int unsigned NQ = QUEUES_DEF;
    localparam int unsigned NM = MSGS_DEF;

    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic                status;
        logic [MLEN_W-1:0]   msg_length;
        logic [SENDER_W-1:0] msg_sender;
        logic [DATA_W-1:0]   msg_data;
        logic [USED_W-1:0]   slots_in_use;
    } t_mbox_result;

    bit                  q_live      [NQ];
    logic [KEY_W-1:0]    q_name      [NQ];
    int unsigned         q_head      [NQ];
    int unsigned         q_tail      [NQ];
    int unsigned         q_fill      [NQ];
    logic [DATA_W-1:0]   ring_data   [NQ*NM];
    logic [MLEN_W-1:0]   ring_len    [NQ*NM];
    logic [SENDER_W-1:0] ring_sender [NQ*NM];

    t_mbox_result expected_results[$];
    int           mismatch_cnt = 0;

    // name stops at the first zero byte or after NAME_BYTES_DEF bytes
    function automatic logic [KEY_W-1:0] canonical_name(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] nm;
        bit               alive;
        nm    = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (key[8*i +: 8] == 8'h00 || i >= NAME_BYTES_DEF) begin
                alive = 1'b0;
            end
            if (alive) begin
                nm[8*i +: 8] = key[8*i +: 8];
            end
        end
        return nm;
    endfunction

    function automatic logic [DATA_W-1:0] low_bytes(input logic [DATA_W-1:0] word,
                                                    input int unsigned nbytes);
        logic [DATA_W-1:0] kept;
        kept = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) begin
                kept[8*i +: 8] = word[8*i +: 8];
            end
        end
        return kept;
    endfunction

    function automatic int lookup_queue(input logic [KEY_W-1:0] nm);
        for (int i = 0; i < NQ; i++) begin
            if (q_live[i] && q_name[i] == nm) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_queue(input int s);
        q_live[s] = 1'b0;
        q_name[s] = '0;
        q_head[s] = 0;
        q_tail[s] = 0;
        q_fill[s] = 0;
    endfunction

    // existing slot, else lowest free one
    function automatic int claim_queue(input logic [KEY_W-1:0] nm);
        int s;
        s = lookup_queue(nm);
        if (s >= 0) begin
            return s;
        end
        for (int i = 0; i < NQ; i++) begin
            if (!q_live[i]) begin
                drop_queue(i);
                q_live[i] = 1'b1;
                q_name[i] = nm;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_mbox_result predict_mailbox(input t_kind               op,
                                                     input logic [KEY_W-1:0]    key,
                                                     input logic [SENDER_W-1:0] sender,
                                                     input logic [LEN_W-1:0]    req_len,
                                                     input logic [DATA_W-1:0]   payload);
        t_mbox_result     r;
        logic [KEY_W-1:0] nm;
        int               s;
        int unsigned      pos;
        int unsigned      nbytes;
        int unsigned      used;
        r  = '0;
        nm = canonical_name(key);
        case (op)
            KIND_CREATE: begin
                if (claim_queue(nm) < 0) begin
                    r.status = ST_FAIL;
                end
            end
            KIND_POST: begin
                s = claim_queue(nm);
                if (s < 0) begin
                    r.status = ST_FAIL;
                end else if (q_fill[s] >= NM) begin
                    r.status = ST_FAIL;
                end else begin
                    nbytes = (req_len > MSG_BYTES_DEF) ? MSG_BYTES_DEF : req_len;
                    pos    = s * NM + q_tail[s];
                    ring_data[pos]   = low_bytes(payload, nbytes);
                    ring_len[pos]    = MLEN_W'(nbytes);
                    ring_sender[pos] = sender;
                    q_tail[s] = (q_tail[s] + 1) % NM;
                    q_fill[s]++;
                end
            end
            KIND_RECEIVE: begin
                s = lookup_queue(nm);
                if (s < 0) begin
                    r.status = ST_FAIL;
                end else if (q_fill[s] == 0) begin
                    r.status = ST_FAIL;
                end else begin
                    pos          = s * NM + q_head[s];
                    r.msg_length = ring_len[pos];
                    r.msg_sender = ring_sender[pos];
                    r.msg_data   = low_bytes(ring_data[pos], ring_len[pos]);
                    q_head[s] = (q_head[s] + 1) % NM;
                    q_fill[s]--;
                end
            end
            default: begin
                s = lookup_queue(nm);
                if (s >= 0) begin
                    drop_queue(s);
                end
            end
        endcase
        used = 0;
        for (int i = 0; i < NQ; i++) begin
            if (q_live[i]) begin
                used++;
            end
        end
        r.slots_in_use = USED_W'(used);
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mbox_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                drop_queue(i);
            end
            expected_results.delete();
        end else begin
            // result first: it can never belong to a request accepted at this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("msg_length", want.msg_length, i_rsp.msg_length);
                    check_field("msg_sender", want.msg_sender, i_rsp.msg_sender);
                    check_field("msg_data", want.msg_data, i_rsp.msg_data);
                    check_field("slots_in_use", want.slots_in_use, i_rsp.slots_in_use);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(predict_mailbox(t_kind'(i_req.kind),
                    i_req.name_key, i_req.sender_id, i_req.length, i_req.payload));
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_results.size();
    end

endmodule

### verif/tb_named_mailbox_queue_engine_top.sv
// ----------------------------------------------------------------------------
// tb_named_mailbox_queue_engine_top
// Drives create, post, receive and destroy operations into the mailbox engine:
// a short directed run over empty names, aliased names, length clamping and
// empty or unknown queues, then random sequences of mixed traffic, ring floods,
// destroy churn, slot table fills and noise. Sender bursts and receiver stalls
// are random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_named_mailbox_queue_engine_top;
    import nmqe_pkg::*;

    localparam int unsigned TARGET_OPS = 1700;
    localparam int unsigned POOL_SIZE  = 24;
    localparam int unsigned DRAIN_CYC  = 8;

    typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;
    typedef enum int unsigned {SEQ_MIX, SEQ_FLOOD, SEQ_CHURN, SEQ_FILL, SEQ_NOISE} t_seq;

    logic             clk = 1'b0;
    logic             rst_n;
    int               pending;
    int               mismatches;
    int unsigned      ops_sent;
    int unsigned      burst_left;
    logic [KEY_W-1:0] name_pool [POOL_SIZE];

    nmqe_req_if req_ch ();
    nmqe_rsp_if rsp_ch ();

    named_mailbox_queue_engine_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    nmqe_mailbox_checker mbox_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pool name, sometimes with random junk above the terminating zero byte
    function automatic logic [KEY_W-1:0] pool_key(input int unsigned idx);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] junk;
        int unsigned      n;
        k    = name_pool[idx];
        n    = 8;
        junk = {$urandom, $urandom};
        for (int i = 7; i >= 0; i--) begin
            if (k[8*i +: 8] == 8'h00) begin
                n = i;
            end
        end
        if (n < 7 && $urandom_range(0, 1) == 1) begin
            k = k | (junk << (8 * (n + 1)));
        end
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(0, 3) == 0) begin
            return LEN_W'($urandom_range(0, 255));
        end
        return LEN_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SENDER_W-1:0] pick_sender();
        if ($urandom_range(0, 7) == 0) begin
            return '0;
        end
        return SENDER_W'($urandom_range(0, 65535));
    endfunction

    // bursts of random length, with a random gap ahead of most of them
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_op(input t_kind k, input logic [KEY_W-1:0] key,
                           input logic [SENDER_W-1:0] snd, input logic [LEN_W-1:0] len,
                           input logic [DATA_W-1:0] data);
        pace();
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= k;
        req_ch.name_key  <= key;
        req_ch.sender_id <= snd;
        req_ch.length    <= len;
        req_ch.payload   <= data;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        ops_sent++;
    endtask

    task automatic send_random(input t_kind k, input logic [KEY_W-1:0] key);
        send_op(k, key, pick_sender(), pick_len(), {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver stall pattern, switching to a random mode after a random run
    initial begin
        t_rx_mode    rx_mode;
        int unsigned rx_left;
        int unsigned rx_tick;
        rx_mode = RX_OPEN;
        rx_left = 0;
        rx_tick = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   rsp_ch.ready <= 1'b1;
                RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 11) == 0);
                default:   rsp_ch.ready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    initial begin
        logic [KEY_W-1:0] noise_keys [4];
        logic [KEY_W-1:0] w;
        t_seq             seq;
        int unsigned      pick;
        int unsigned      span;
        int unsigned      idx;
        int unsigned      cnt;
        bit               paused;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_CREATE;
        req_ch.name_key  <= '0;
        req_ch.sender_id <= '0;
        req_ch.length    <= '0;
        req_ch.payload   <= '0;
        ops_sent   = 0;
        burst_left = 0;
        paused     = 1'b0;

        // entry 0 is the empty name, the rest have 1 to 8 nonzero bytes
        for (int i = 0; i < POOL_SIZE; i++) begin
            w = '0;
            for (int j = 0; j < ((i == 0) ? 0 : 1 + (i % 8)); j++) begin
                w[8*j +: 8] = 8'($urandom_range(1, 255));
            end
            name_pool[i] = w;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown and empty queues, empty name, clamping, aliasing
        send_op(KIND_RECEIVE, '0, '0, '0, '0);
        send_op(KIND_DESTROY, '1, '1, '1, '1);
        send_op(KIND_CREATE, '0, '0, '0, '0);
        send_op(KIND_CREATE, 64'h1234_5678_0000_0000, '0, '0, '0);
        send_op(KIND_POST, '0, 16'hFFFF, 8'hFF, '1);
        send_op(KIND_POST, '0, '0, 8'h00, '1);
        send_op(KIND_POST, '0, 16'h0001, 8'h03, 64'h0123_4567_89AB_CDEF);
        send_op(KIND_RECEIVE, '0, '0, '0, '0);
        send_op(KIND_RECEIVE, '0, '0, '0, '0);
        send_op(KIND_RECEIVE, '0, '0, '0, '0);
        send_op(KIND_RECEIVE, '0, '0, '0, '0);
        send_op(KIND_POST, 64'h5A5A_5A5A_5A00_4241, 16'h8000, 8'h08, 64'hFEDC_BA98_7654_3210);
        send_op(KIND_RECEIVE, 64'h0000_0000_0000_4241, '0, '0, '0);
        send_op(KIND_DESTROY, 64'hA5A5_0000_0000_4241, '0, '0, '0);
        send_op(KIND_RECEIVE, 64'h0000_0000_0000_4241, '0, '0, '0);
        send_op(KIND_CREATE, '1, '0, '0, '0);
        send_op(KIND_POST, '1, 16'h7FFF, 8'h09, 64'h8000_0000_0000_0001);
        send_op(KIND_RECEIVE, '1, '0, '0, '0);
        send_op(KIND_DESTROY, '0, '0, '0, '0);
        send_op(KIND_DESTROY, '1, '0, '0, '0);

        while (ops_sent < TARGET_OPS) begin
            if (!paused && ops_sent >= TARGET_OPS / 2) begin
                paused = 1'b1;
                wait_idle();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                seq = SEQ_MIX;
            end else if (pick < 75) begin
                seq = SEQ_FLOOD;
            end else if (pick < 85) begin
                seq = SEQ_CHURN;
            end else if (pick < 90) begin
                seq = SEQ_FILL;
            end else begin
                seq = SEQ_NOISE;
            end
            case (seq)
                SEQ_MIX: begin
                    span = $urandom_range(3, POOL_SIZE);
                    cnt  = $urandom_range(8, 30);
                    repeat (cnt) begin
                        idx  = $urandom_range(0, span - 1);
                        pick = $urandom_range(0, 99);
                        if (pick < 40) begin
                            send_random(KIND_POST, pool_key(idx));
                        end else if (pick < 75) begin
                            send_random(KIND_RECEIVE, pool_key(idx));
                        end else if (pick < 87) begin
                            send_random(KIND_CREATE, pool_key(idx));
                        end else begin
                            send_random(KIND_DESTROY, pool_key(idx));
                        end
                    end
                end
                SEQ_FLOOD: begin
                    // 12 to 20 posts, which can hit a full ring, then as many receives plus up to two more
                    idx = $urandom_range(0, POOL_SIZE - 1);
                    cnt = $urandom_range(12, 20);
                    repeat (cnt) send_random(KIND_POST, pool_key(idx));
                    repeat (cnt + $urandom_range(0, 2)) send_random(KIND_RECEIVE, pool_key(idx));
                end
                SEQ_CHURN: begin
                    repeat ($urandom_range(3, 8)) begin
                        send_random(KIND_DESTROY, pool_key($urandom_range(0, POOL_SIZE - 1)));
                    end
                end
                SEQ_FILL: begin
                    // more names than slots: late creates and posts find no slot
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        send_random(($urandom_range(0, 1) == 1) ? KIND_CREATE : KIND_POST,
                                    pool_key(i));
                    end
                end
                default: begin
                    foreach (noise_keys[i]) begin
                        noise_keys[i] = {$urandom, $urandom};
                        send_random(t_kind'($urandom_range(0, 3)), noise_keys[i]);
                    end
                    foreach (noise_keys[i]) begin
                        send_random(KIND_DESTROY, noise_keys[i]);
                    end
                end
            endcase
        end

        wait_idle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(64'd20 * 64'd1_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
